>>> hw/rtl/ucd_pkg.sv
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared types and constants for the UTF-8 / GBK / UTF-16LE charset detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ucd_pkg;

   // Encoding codes carried on the result channel.
   typedef enum logic [1:0] {
      ENC_GBK     = 2'd0,
      ENC_UTF8    = 2'd1,
      ENC_UNICODE = 2'd2
   } enc_type;

   // Byte-order mark of a UTF-16LE string.
   localparam logic [7:0] BOM_FIRST  = 8'hFF;
   localparam logic [7:0] BOM_SECOND = 8'hFE;

   // Lead and continuation byte classes.
   localparam logic [7:0] HIGH_BIT_MASK = 8'h80;
   localparam logic [7:0] LEAD2_MASK    = 8'hE0;
   localparam logic [7:0] LEAD2_CODE    = 8'hC0;
   localparam logic [7:0] LEAD3_MASK    = 8'hF0;
   localparam logic [7:0] LEAD3_CODE    = 8'hE0;
   localparam logic [7:0] CONT_MASK     = 8'hC0;
   localparam logic [7:0] CONT_CODE     = 8'h80;

   // One string byte as it travels through the block.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } item_type;

endpackage : ucd_pkg

`default_nettype wire

>>> hw/rtl/ucd_scan.sv
// ----------------------------------------------------------------------------
// ucd_scan
// Scan state and per-byte decision logic; produces the verdict of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module ucd_scan
   import ucd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire item_type   item,
   output logic [1:0]      encoding
);

   logic [7:0] older_ff, older_in;
   logic [7:0] newer_ff, newer_in;
   logic [1:0] seen_ff, seen_in;
   logic       skip_ff, skip_in;
   logic       decided_ff, decided_in;
   enc_type    verdict_ff, verdict_in;

   // Decision for the current byte, before the end-of-string clear.
   logic       dec_decided;
   enc_type    dec_verdict;
   logic       dec_skip;
   logic [7:0] cur;

   assign cur = item.data_byte;

   always_comb begin
      dec_decided = decided_ff;
      dec_verdict = verdict_ff;
      dec_skip    = skip_ff;
      if (!decided_ff) begin
         if (seen_ff == 2'd1) begin
            if (newer_ff == BOM_FIRST && cur == BOM_SECOND) begin
               dec_decided = 1'b1;
               dec_verdict = ENC_UNICODE;
            end
         end else if (seen_ff != 2'd0) begin
            // Judge the position whose lead is the older window byte.
            if (skip_ff) begin
               dec_skip = 1'b0;
            end else if ((older_ff & HIGH_BIT_MASK) != 8'h00) begin
               dec_decided = 1'b1;
               dec_verdict = ENC_GBK;
               if ((newer_ff & HIGH_BIT_MASK) == 8'h00) begin
                  dec_verdict = ENC_GBK;
               end else if ((older_ff & LEAD2_MASK) == LEAD2_CODE) begin
                  if ((newer_ff & CONT_MASK) != CONT_CODE) begin
                     // No decision yet: the verdict keeps its current value.
                     dec_decided = 1'b0;
                     dec_verdict = verdict_ff;
                     dec_skip    = 1'b1;
                  end
               end else if ((older_ff & LEAD3_MASK) == LEAD3_CODE) begin
                  if ((newer_ff & CONT_MASK) == CONT_CODE &&
                      (cur & CONT_MASK) == CONT_CODE) begin
                     dec_verdict = ENC_UTF8;
                  end
               end
            end
         end
      end
   end

   // A string of one byte is GBK; otherwise the verdict as it now stands.
   assign encoding = (seen_ff == 2'd0) ? ENC_GBK : dec_verdict;

   always_comb begin
      older_in   = older_ff;
      newer_in   = newer_ff;
      seen_in    = seen_ff;
      skip_in    = skip_ff;
      decided_in = decided_ff;
      verdict_in = verdict_ff;
      if (step) begin
         if (item.is_last) begin
            older_in   = 8'h00;
            newer_in   = 8'h00;
            seen_in    = 2'd0;
            skip_in    = 1'b0;
            decided_in = 1'b0;
            verdict_in = ENC_UTF8;
         end else begin
            older_in   = newer_ff;
            newer_in   = cur;
            seen_in    = (seen_ff == 2'd3) ? seen_ff : seen_ff + 2'd1;
            skip_in    = dec_skip;
            decided_in = dec_decided;
            verdict_in = dec_verdict;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff   <= 8'h00;
         newer_ff   <= 8'h00;
         seen_ff    <= 2'd0;
         skip_ff    <= 1'b0;
         decided_ff <= 1'b0;
         verdict_ff <= ENC_UTF8;
      end else begin
         older_ff   <= older_in;
         newer_ff   <= newer_in;
         seen_ff    <= seen_in;
         skip_ff    <= skip_in;
         decided_ff <= decided_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule : ucd_scan

`default_nettype wire

>>> hw/rtl/utf8_gbk_charset_detector.sv
// ----------------------------------------------------------------------------
// utf8_gbk_charset_detector
// Streaming classifier of a byte string as GBK, UTF-8 or UTF-16LE.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one string byte per item, with req_is_last set on
// the final byte of the string. An item is taken at a rising edge where
// req_valid is high and req_stall is low. The block sends one item on the
// rsp channel for every string, on its final byte: rsp_encoding is 0 for
// GBK, 1 for UTF-8 and 2 for UTF-16LE. Bytes that are not last give no
// result item.
// The edge that accepts the final byte of a string loads the input register;
// the verdict then loads the result register once that has room. Throughput
// is one byte per cycle, set by the single register-to-register pass of the
// scan logic, while no final byte waits on a stalled result register.
// A synchronous, active-high reset empties both registers and returns the
// scan state to the start of a string. When the receiver raises rsp_stall
// the waiting verdict holds; bytes that are not last keep flowing, and the
// input register stalls the sender only when a final byte would need the
// occupied result register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_gbk_charset_detector
   import ucd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_is_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_encoding
);

   // Input register: holds one accepted item until the scan logic takes it.
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_enc_ff;

   logic       req_take;
   logic       out_free;
   logic       advance;
   logic [1:0] scan_encoding;

   // The result register can take a new verdict when empty or draining.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Only a final byte needs room in the result register.
   assign advance  = in_valid_ff && (!in_item_ff.is_last || out_free);

   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_item_ff.is_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   ucd_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (in_item_ff),
      .encoding (scan_encoding)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load only on their handshakes.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.data_byte <= req_data_byte;
         in_item_ff.is_last   <= req_is_last;
      end
      if (advance && in_item_ff.is_last) begin
         rsp_enc_ff <= scan_encoding;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_encoding = rsp_enc_ff;

endmodule : utf8_gbk_charset_detector

`default_nettype wire
